/* src/bart_pkg.sv */
package bart_pkg;

    localparam int RULE_DEPTH_DEF   = 32;
    localparam int OUTPUT_COUNT_DEF = 8;
    localparam int QDEPTH_DEF       = 2;

    localparam logic [2:0] CMD_PRESS = 3'd0;
    localparam logic [2:0] CMD_APPEND = 3'd1;
    localparam logic [2:0] CMD_CLEAR = 3'd2;
    localparam logic [2:0] CMD_SET_TIMER = 3'd3;
    localparam logic [2:0] CMD_READ_TIMER = 3'd4;

    localparam logic [2:0] RES_ON = 3'd0;
    localparam logic [2:0] RES_OFF = 3'd1;
    localparam logic [2:0] RES_TOGGLE = 3'd2;
    localparam logic [2:0] RES_DONE = 3'd3;
    localparam logic [2:0] RES_OK = 3'd4;
    localparam logic [2:0] RES_FULL = 3'd5;
    localparam logic [2:0] RES_BAD_OUT = 3'd6;
    localparam logic [2:0] RES_TIMER = 3'd7;

    localparam logic [1:0] ACT_ON = 2'd0;
    localparam logic [1:0] ACT_OFF = 2'd1;
    localparam logic [1:0] ACT_TOGGLE = 2'd2;

    localparam logic [1:0] TRIG_SHORT_DOUBLE = 2'd0;
    localparam logic [1:0] TRIG_SHORT = 2'd1;
    localparam logic [1:0] TRIG_LONG = 2'd2;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  sender_id;
        logic [7:0]  mask_or_forced_source;
        logic [7:0]  states_or_current_outputs;
        logic [15:0] short_clicks;
        logic [15:0] long_clicks;
        logic [15:0] double_clicks;
        logic [3:0]  button_number;
        logic [1:0]  trigger_kind;
        logic [1:0]  action_kind;
        logic [7:0]  output_number;
        logic [15:0] timer_value;
    } item_t;

    typedef struct packed {
        logic [7:0]  src;
        logic [7:0]  mask;
        logic [7:0]  states;
        logic [3:0]  button;
        logic [1:0]  trigger;
        logic [1:0]  action;
        logic [7:0]  outnum;
        logic [15:0] timer;
    } rule_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  target;
        logic [15:0] timer;
        logic        last;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WALK,
        ST_DONE
    } walk_state_t;

endpackage

/* src/bart_front.sv */
module bart_front #(
    parameter int QDEPTH = bart_pkg::QDEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bart_pkg::item_t      in_item,
    output logic                 q_valid,
    input  logic                 q_ready,
    output bart_pkg::item_t      q_item
);
    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    bart_pkg::item_t    mem [QDEPTH];
    logic [AW-1:0]      wp_reg, rp_reg;
    logic [AW:0]        cnt_reg;
    logic               known;
    logic               push, pop;

    assign known    = in_item.cmd <= bart_pkg::CMD_READ_TIMER;
    assign in_ready = cnt_reg != QDEPTH[AW:0];
    assign push     = in_valid && in_ready && known;
    assign q_valid  = cnt_reg != '0;
    assign pop      = q_valid && q_ready;
    assign q_item   = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == AW'(QDEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == AW'(QDEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QDEPTH[AW:0]) else $error("queue overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == QDEPTH[AW:0]) |-> !push) else $error("push when full");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != '0) else $error("pop when empty");
endmodule

/* src/bart_back.sv */
module bart_back #(
    parameter int RULE_DEPTH   = bart_pkg::RULE_DEPTH_DEF,
    parameter int OUTPUT_COUNT = bart_pkg::OUTPUT_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  bart_pkg::item_t    q_item,
    input  logic [15:0]        marker,
    output logic               out_valid,
    input  logic               out_ready,
    output bart_pkg::result_t  out_res
);
    localparam int RW = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
    localparam int CW = $clog2(RULE_DEPTH + 1);

    bart_pkg::rule_t    rules [RULE_DEPTH];
    logic [15:0]        dtm_reg [8];
    logic [CW-1:0]      count_reg;
    bart_pkg::walk_state_t st_reg, st_next;
    bart_pkg::item_t    cur_reg;
    logic [CW-1:0]      idx_reg, idx_next;
    bart_pkg::rule_t    rd_reg;
    logic               ov_reg;
    bart_pkg::result_t  res_reg, res_next;
    logic               ov_next;
    logic               take;
    logic               rd_en;
    logic [7:0]         sender;
    logic [15:0]        bit_sel;
    logic               hit, match;
    logic [15:0]        tmr;
    logic               out_free;
    logic               dtm_we;
    logic [2:0]         dtm_wa;
    logic [15:0]        dtm_wd;
    logic               app_we;
    logic               cnt_clr;

    assign out_valid = ov_reg;
    assign out_res   = res_reg;
    assign out_free  = !ov_reg || out_ready;

    assign sender  = (cur_reg.mask_or_forced_source != 8'd0) ?
                     cur_reg.mask_or_forced_source : cur_reg.sender_id;
    assign bit_sel = 16'd1 << rd_reg.button;
    always_comb
    begin
        case (rd_reg.trigger)
            bart_pkg::TRIG_SHORT_DOUBLE:
                hit = |((cur_reg.short_clicks | cur_reg.double_clicks) & bit_sel);
            bart_pkg::TRIG_SHORT: hit = |(cur_reg.short_clicks & bit_sel);
            bart_pkg::TRIG_LONG:  hit = |(cur_reg.long_clicks & bit_sel);
            default:              hit = |(cur_reg.double_clicks & bit_sel);
        endcase
    end
    assign match = (rd_reg.src == sender) && hit &&
                   ((cur_reg.states_or_current_outputs & rd_reg.mask) == rd_reg.states);
    assign tmr = (rd_reg.timer == marker) ? dtm_reg[rd_reg.outnum[2:0]] : rd_reg.timer;

    always_comb
    begin
        st_next  = st_reg;
        idx_next = idx_reg;
        res_next = res_reg;
        ov_next  = ov_reg && !out_ready;
        take     = 1'b0;
        rd_en    = 1'b0;
        dtm_we   = 1'b0;
        dtm_wa   = q_item.output_number[2:0];
        dtm_wd   = q_item.timer_value;
        app_we   = 1'b0;
        cnt_clr  = 1'b0;
        case (st_reg)
            bart_pkg::ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    take = 1'b1;
                    res_next = '{kind: bart_pkg::RES_OK, target: 8'd0, timer: 16'd0,
                                 last: 1'b1};
                    case (q_item.cmd)
                        bart_pkg::CMD_PRESS:
                        begin
                            idx_next = count_reg;
                            st_next  = (count_reg == '0) ? bart_pkg::ST_DONE
                                                         : bart_pkg::ST_READ;
                        end
                        bart_pkg::CMD_APPEND:
                        begin
                            ov_next = 1'b1;
                            if (count_reg < CW'(RULE_DEPTH))
                                app_we = 1'b1;
                            else
                                res_next.kind = bart_pkg::RES_FULL;
                        end
                        bart_pkg::CMD_CLEAR:
                        begin
                            ov_next = 1'b1;
                            cnt_clr = 1'b1;
                        end
                        bart_pkg::CMD_SET_TIMER:
                        begin
                            ov_next = 1'b1;
                            if (q_item.output_number >= 8'(OUTPUT_COUNT))
                            begin
                                res_next.kind   = bart_pkg::RES_BAD_OUT;
                                res_next.target = q_item.output_number;
                            end
                            else
                                dtm_we = 1'b1;
                        end
                        default:
                        begin
                            ov_next = 1'b1;
                            res_next.target = q_item.output_number;
                            if (q_item.output_number >= 8'(OUTPUT_COUNT))
                                res_next.kind = bart_pkg::RES_BAD_OUT;
                            else
                            begin
                                res_next.kind  = bart_pkg::RES_TIMER;
                                res_next.timer = dtm_reg[q_item.output_number[2:0]];
                            end
                        end
                    endcase
                end
            end
            bart_pkg::ST_READ:
            begin
                rd_en    = 1'b1;
                idx_next = idx_reg - 1'b1;
                st_next  = bart_pkg::ST_WALK;
            end
            bart_pkg::ST_WALK:
            begin
                if (!match || (rd_reg.outnum < 8'(OUTPUT_COUNT) &&
                               rd_reg.action != bart_pkg::ACT_ON &&
                               rd_reg.action != bart_pkg::ACT_OFF &&
                               rd_reg.action != bart_pkg::ACT_TOGGLE))
                begin
                    st_next = (idx_reg == '0) ? bart_pkg::ST_DONE : bart_pkg::ST_READ;
                end
                else if (out_free)
                begin
                    ov_next = 1'b1;
                    res_next.last   = 1'b0;
                    res_next.target = rd_reg.outnum;
                    res_next.timer  = tmr;
                    if (rd_reg.outnum >= 8'(OUTPUT_COUNT))
                    begin
                        res_next.kind  = bart_pkg::RES_BAD_OUT;
                        res_next.timer = 16'd0;
                        st_next = bart_pkg::ST_DONE;
                    end
                    else
                    begin
                        case (rd_reg.action)
                            bart_pkg::ACT_ON:  res_next.kind = bart_pkg::RES_ON;
                            bart_pkg::ACT_OFF:
                            begin
                                res_next.kind  = bart_pkg::RES_OFF;
                                res_next.timer = 16'd0;
                            end
                            default: res_next.kind = bart_pkg::RES_TOGGLE;
                        endcase
                        st_next = (idx_reg == '0) ? bart_pkg::ST_DONE
                                                  : bart_pkg::ST_READ;
                    end
                end
            end
            default:
            begin
                if (out_free)
                begin
                    ov_next  = 1'b1;
                    res_next = '{kind: bart_pkg::RES_DONE, target: 8'd0, timer: 16'd0,
                                 last: 1'b1};
                    st_next  = bart_pkg::ST_IDLE;
                end
            end
        endcase
    end

    assign q_ready = take;

    always_ff @(posedge clk)
    begin
        if (app_we)
        begin
            rules[count_reg[RW-1:0]] <= '{src: q_item.sender_id,
                mask: q_item.mask_or_forced_source,
                states: q_item.states_or_current_outputs,
                button: q_item.button_number, trigger: q_item.trigger_kind,
                action: q_item.action_kind, outnum: q_item.output_number,
                timer: q_item.timer_value};
        end
        if (rd_en)
        begin
            rd_reg <= rules[idx_next[RW-1:0]];
        end
        if (take)
        begin
            cur_reg <= q_item;
        end
        res_reg <= res_next;
        idx_reg <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= bart_pkg::ST_IDLE;
            ov_reg    <= 1'b0;
            count_reg <= '0;
            for (int k = 0; k < 8; k++)
                dtm_reg[k] <= 16'd0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
            if (cnt_clr)
                count_reg <= '0;
            else if (app_we)
                count_reg <= count_reg + 1'b1;
            if (dtm_we)
                dtm_reg[dtm_wa] <= dtm_wd;
        end
    end

    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(RULE_DEPTH)) else $error("rule count overflow");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> st_reg == bart_pkg::ST_IDLE) else $error("take while busy");
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == bart_pkg::ST_DONE && st_next == bart_pkg::ST_IDLE) |=>
        (ov_reg && res_reg.last)) else $error("done not last");
endmodule

/* src/button_action_rule_table.sv */
// Button action rule table.
// Slave stream s_axis_*: one command item per transfer (press, append rule,
// clear rules, set or read a default timer); tuser carries the command code.
// Master stream m_axis_*: result items; tuser carries the result kind and
// tlast marks the final result of a command. Unknown commands give none.
// cfg_valid/cfg_ready writes the default timer marker; always ready.
// Items pass a QDEPTH-entry queue (two by default) to the executor. Append,
// clear, set and read give one result each. A press reads each stored rule
// from rule memory, newest first, then compares it, and ends with a done
// result; the executor handles one command at a time.
// Reset empties the queue, clears the rule count and default timers and sets
// the marker to 65535. A stalled m_axis_tready holds the result register;
// the walk waits at a matching rule; the queue keeps accepting until full.
module button_action_rule_table #(
    parameter int RULE_DEPTH   = bart_pkg::RULE_DEPTH_DEF,
    parameter int OUTPUT_COUNT = bart_pkg::OUTPUT_COUNT_DEF,
    parameter int QDEPTH       = bart_pkg::QDEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // sender_id, mask_or_forced_source, states_or_current_outputs,
    // short_clicks, long_clicks, double_clicks, button_number, trigger_kind,
    // action_kind, output_number, timer_value
    input  logic [103:0] s_axis_tdata,
    // cmd
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // target_output, timer_out
    output logic [23:0]  m_axis_tdata,
    // result_kind
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data
);
    bart_pkg::item_t   in_item, q_item;
    bart_pkg::result_t res;
    logic              q_valid, q_ready;
    logic [15:0]       marker_reg;

    assign in_item = '{cmd: s_axis_tuser, sender_id: s_axis_tdata[7:0],
        mask_or_forced_source: s_axis_tdata[15:8],
        states_or_current_outputs: s_axis_tdata[23:16],
        short_clicks: s_axis_tdata[39:24], long_clicks: s_axis_tdata[55:40],
        double_clicks: s_axis_tdata[71:56], button_number: s_axis_tdata[75:72],
        trigger_kind: s_axis_tdata[77:76], action_kind: s_axis_tdata[79:78],
        output_number: s_axis_tdata[87:80], timer_value: s_axis_tdata[103:88]};

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            marker_reg <= 16'hFFFF;
        else if (cfg_valid)
            marker_reg <= cfg_data;
    end

    bart_front #(.QDEPTH(QDEPTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    bart_back #(.RULE_DEPTH(RULE_DEPTH), .OUTPUT_COUNT(OUTPUT_COUNT)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .marker(marker_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
    );

    assign m_axis_tdata = {res.timer, res.target};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;
endmodule
